/* hdl/gnz_pkg.sv */
// Package for the gradient noise block: command codes and fixed sizes.
// Used by every module in the hdl folder; depends on nothing else.
`default_nettype none
package gnz_pkg;
  localparam int TABLE_SIZE = 256;
  localparam int IDX_W = $clog2(TABLE_SIZE);
  localparam int FRAC_BITS_DEF = 16;
  localparam int COORD_W = 32;
  localparam int NOISE_W = 16;
  localparam int CORNERS = 8;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_EVAL = 1'b1;
endpackage
`default_nettype wire

/* hdl/gnz_perm_ram.sv */
// One copy of the permutation table: one write port, one registered read port.
// Depends on gnz_pkg for the table size.
`default_nettype none
module gnz_perm_ram import gnz_pkg::*; (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic             we,
  input  wire logic [IDX_W-1:0] waddr,
  input  wire logic [7:0]       wdata,
  input  wire logic [IDX_W-1:0] raddr,
  output logic      [7:0]       rdata
);
  logic [7:0] mem [TABLE_SIZE];

  // Write and read only while the pipeline advances.
  always_ff @(posedge clk) begin
    if (en && we) begin
      mem[waddr] <= wdata;
    end
    if (en) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

/* hdl/gnz_fade.sv */
// Three-stage quintic fade 6t^5 - 15t^4 + 10t^3 on one fraction.
// Depends on gnz_pkg.
`default_nettype none
module gnz_fade import gnz_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 en,
  input  wire logic [FRAC_BITS-1:0] frac,
  output logic      [FRAC_BITS:0]   fade
);
  localparam int F = FRAC_BITS;
  localparam logic [F+5:0] TEN_ONE = (F+6)'(10) << F;
  localparam logic [F:0] ONE = (F+1)'(1) << F;

  logic [F-1:0]   t2;
  logic [F-1:0]   f1;
  logic [F-1:0]   t3;
  logic [F+3:0]   q;
  logic [2*F-1:0] sq;
  logic [2*F-1:0] cube;
  logic [F+5:0]   q_s;
  logic [2*F+3:0] prod;

  always_comb begin
    sq = frac * frac;
    cube = t2 * f1;
    q_s = (F+6)'(6) * {6'b0, t2} - (F+6)'(15) * {6'b0, f1} + TEN_ONE;
    prod = {4'b0, t3} * {F'(0), q};
  end

  // Stage one: square; stage two: cube and polynomial; stage three: product.
  always_ff @(posedge clk) begin
    if (en) begin
      t2 <= sq[2*F-1:F];
      f1 <= frac;
      t3 <= cube[2*F-1:F];
      q <= q_s[F+5] ? '0 : q_s[F+3:0];
      if (prod[2*F+3:F] > {3'b0, ONE}) begin
        fade <= ONE;
      end else begin
        fade <= prod[2*F:F];
      end
    end
  end
endmodule
`default_nettype wire

/* hdl/gnz_lerp.sv */
// Linear blend a + floor(t * (b - a) / 2^F) on signed fixed-point values.
// Depends on gnz_pkg.
`default_nettype none
module gnz_lerp import gnz_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic        [FRAC_BITS:0]   t,
  input  wire logic signed [FRAC_BITS+2:0] a,
  input  wire logic signed [FRAC_BITS+2:0] b,
  output logic signed      [FRAC_BITS+2:0] y
);
  localparam int VW = FRAC_BITS + 3;

  logic signed [VW:0]             diff;
  logic signed [VW+FRAC_BITS+2:0] prod;
  logic signed [VW+FRAC_BITS+2:0] sh;

  // Arithmetic shift gives the floor toward minus infinity.
  always_comb begin
    diff = {b[VW-1], b} - {a[VW-1], a};
    prod = $signed({1'b0, t}) * diff;
    sh = prod >>> FRAC_BITS;
    y = a + sh[VW-1:0];
  end
endmodule
`default_nettype wire

/* hdl/gradient_noise_3d.sv */
// Three-dimensional improved gradient noise: top level.
// Uses gnz_pkg, gnz_perm_ram, gnz_fade and gnz_lerp.
//
// Input channel (in_valid / in_stall): command 0 loads table_value into
// permutation entry table_index; command 1 evaluates noise at coord_x,
// coord_y, coord_z (signed, FRAC_BITS fraction bits). Every entry must be
// loaded before the first evaluation.
// Output channel (out_valid / out_stall): one noise_value per evaluate item,
// none per load item, in input order.
// An evaluate item passes the stage registers s1 to s7 and then the output
// register. Throughput: one item per cycle unless out_stall holds the pipeline.
// The table is held in 14 copies, two read by the cell stage, four by the first
// hash stage and eight by the corner hash stage; a load item writes each copy
// as it passes that stage, so reads always see loads in item order.
// Reset clears the pipeline valid bits and out_valid, not noise_value; the table
// contents are undefined until loaded. While the output holds a result and
// out_stall is high, the whole pipeline holds and in_stall is raised.
`default_nettype none
module gradient_noise_3d import gnz_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic                      command,
  input  wire logic        [IDX_W-1:0]   table_index,
  input  wire logic        [7:0]         table_value,
  input  wire logic signed [COORD_W-1:0] coord_x,
  input  wire logic signed [COORD_W-1:0] coord_y,
  input  wire logic signed [COORD_W-1:0] coord_z,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic             [NOISE_W-1:0] noise_value
);
  localparam int F = FRAC_BITS;
  localparam int VW = F + 3;
  localparam int SW = F + 17;
  localparam logic signed [VW-1:0] ONE_S = VW'(1) << F;

  logic en;
  logic in_load;

  // Pipeline registers.
  logic             s1_valid, s1_load;
  logic [IDX_W-1:0] s1_idx;
  logic [7:0]       s1_val;
  logic [F-1:0]     s1_fx, s1_fy, s1_fz;
  logic [IDX_W-1:0] s1_y, s1_z;
  logic             s2_valid, s2_load;
  logic [IDX_W-1:0] s2_idx;
  logic [7:0]       s2_val;
  logic [F-1:0]     s2_fx, s2_fy, s2_fz;
  logic [IDX_W-1:0] s2_z;
  logic             s3_valid;
  logic [F-1:0]     s3_fx, s3_fy, s3_fz;
  logic             s4_valid, s5_valid, s6_valid, s7_valid;
  logic signed [VW-1:0] s4_grad [CORNERS];
  logic signed [VW-1:0] s5_cx [4];
  logic signed [VW-1:0] s6_cy [2];
  logic signed [VW-1:0] s7_res;
  logic [F:0] u4, v4, w4, v5, w5, w6;

  // Memory ports.
  logic [7:0]       p0 [2];
  logic [7:0]       p1 [4];
  logic [7:0]       p2 [CORNERS];
  logic [IDX_W-1:0] a0 [2];
  logic [IDX_W-1:0] a1 [4];
  logic [IDX_W-1:0] a2 [CORNERS];
  logic [IDX_W-1:0] hb [4];

  logic signed [VW-1:0] grad [CORNERS];
  logic signed [VW-1:0] cx [4];
  logic signed [VW-1:0] cy [2];
  logic signed [VW-1:0] cz;
  logic signed [VW:0]   val;
  logic [SW-1:0]        wide;
  logic [SW-1:0]        scaled;

  assign en = !(out_valid && out_stall);
  assign in_stall = !en;
  assign in_load = in_valid && en && (command == CMD_LOAD);

  // Cell stage addresses straight from the input coordinate.
  assign a0[0] = coord_x[F+IDX_W-1:F];
  assign a0[1] = coord_x[F+IDX_W-1:F] + IDX_W'(1);

  // First hash stage: A = perm(X) + Y, B = perm(X+1) + Y.
  always_comb begin
    a1[0] = p0[0] + s1_y;
    a1[1] = p0[0] + s1_y + IDX_W'(1);
    a1[2] = p0[1] + s1_y;
    a1[3] = p0[1] + s1_y + IDX_W'(1);
  end

  // Corner hash stage: order AA, BA, AB, BB, then each plus one.
  always_comb begin
    hb[0] = p1[0] + s2_z;
    hb[1] = p1[2] + s2_z;
    hb[2] = p1[1] + s2_z;
    hb[3] = p1[3] + s2_z;
    for (int i = 0; i < 4; i++) begin
      a2[i] = hb[i];
      a2[i+4] = hb[i] + IDX_W'(1);
    end
  end

  genvar g;
  for (g = 0; g < 2; g++) begin : g_ram0
    gnz_perm_ram u_ram (
      .clk(clk), .en(en), .we(in_load), .waddr(table_index), .wdata(table_value),
      .raddr(a0[g]), .rdata(p0[g])
    );
  end
  for (g = 0; g < 4; g++) begin : g_ram1
    gnz_perm_ram u_ram (
      .clk(clk), .en(en), .we(s1_valid && s1_load), .waddr(s1_idx), .wdata(s1_val),
      .raddr(a1[g]), .rdata(p1[g])
    );
  end
  for (g = 0; g < CORNERS; g++) begin : g_ram2
    gnz_perm_ram u_ram (
      .clk(clk), .en(en), .we(s2_valid && s2_load), .waddr(s2_idx), .wdata(s2_val),
      .raddr(a2[g]), .rdata(p2[g])
    );
  end

  // Gradient per corner: offsets f or f - 1 chosen by the corner bits.
  for (g = 0; g < CORNERS; g++) begin : g_grad
    logic signed [VW-1:0] ox, oy, oz, gu, gv;
    logic [3:0] h;
    always_comb begin
      h = p2[g][3:0];
      ox = $signed({3'b000, s3_fx}) - (((g & 1) != 0) ? ONE_S : '0);
      oy = $signed({3'b000, s3_fy}) - (((g & 2) != 0) ? ONE_S : '0);
      oz = $signed({3'b000, s3_fz}) - (((g & 4) != 0) ? ONE_S : '0);
      gu = (h < 4'd8) ? ox : oy;
      if (h < 4'd4) begin
        gv = oy;
      end else if (h == 4'd12 || h == 4'd14) begin
        gv = ox;
      end else begin
        gv = oz;
      end
      grad[g] = (h[0] ? -gu : gu) + (h[1] ? -gv : gv);
    end
  end

  gnz_fade #(.FRAC_BITS(F)) u_fade_x (.clk(clk), .en(en), .frac(s1_fx), .fade(u4));
  gnz_fade #(.FRAC_BITS(F)) u_fade_y (.clk(clk), .en(en), .frac(s1_fy), .fade(v4));
  gnz_fade #(.FRAC_BITS(F)) u_fade_z (.clk(clk), .en(en), .frac(s1_fz), .fade(w4));

  // Trilinear blend over three stages.
  for (g = 0; g < 4; g++) begin : g_lx
    gnz_lerp #(.FRAC_BITS(F)) u_l (
      .t(u4), .a(s4_grad[2*g]), .b(s4_grad[2*g+1]), .y(cx[g])
    );
  end
  for (g = 0; g < 2; g++) begin : g_ly
    gnz_lerp #(.FRAC_BITS(F)) u_l (
      .t(v5), .a(s5_cx[2*g]), .b(s5_cx[2*g+1]), .y(cy[g])
    );
  end
  gnz_lerp #(.FRAC_BITS(F)) u_lz (.t(w6), .a(s6_cy[0]), .b(s6_cy[1]), .y(cz));

  // Output mapping (res + 1) / 2 to unsigned Q0.16 with saturation.
  always_comb begin
    val = {s7_res[VW-1], s7_res} + {ONE_S[VW-1], ONE_S};
    wide = val[VW] ? '0 : (SW'(val[VW-1:0]) << 15);
    scaled = wide >> F;
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      s5_valid <= 1'b0;
      s6_valid <= 1'b0;
      s7_valid <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= in_valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid && !s2_load;
      s4_valid <= s3_valid;
      s5_valid <= s4_valid;
      s6_valid <= s5_valid;
      s7_valid <= s6_valid;
      out_valid <= s7_valid;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (en) begin
      s1_load <= (command == CMD_LOAD);
      s1_idx <= table_index;
      s1_val <= table_value;
      s1_fx <= coord_x[F-1:0];
      s1_fy <= coord_y[F-1:0];
      s1_fz <= coord_z[F-1:0];
      s1_y <= coord_y[F+IDX_W-1:F];
      s1_z <= coord_z[F+IDX_W-1:F];
      s2_load <= s1_load;
      s2_idx <= s1_idx;
      s2_val <= s1_val;
      s2_fx <= s1_fx;
      s2_fy <= s1_fy;
      s2_fz <= s1_fz;
      s2_z <= s1_z;
      s3_fx <= s2_fx;
      s3_fy <= s2_fy;
      s3_fz <= s2_fz;
      s4_grad <= grad;
      s5_cx <= cx;
      v5 <= v4;
      w5 <= w4;
      s6_cy <= cy;
      w6 <= w5;
      s7_res <= cz;
      if (scaled[SW-1:NOISE_W] != '0) begin
        noise_value <= '1;
      end else begin
        noise_value <= scaled[NOISE_W-1:0];
      end
    end
  end
endmodule
`default_nettype wire

/* test/gradient_noise_3d_tb.sv */
// Testbench for gradient_noise_3d: drives load and evaluate items and checks
// each noise result against a predictor or a value typed in by hand. Depends on gnz_pkg and the block.
`default_nettype none
module gradient_noise_3d_tb;
  import gnz_pkg::*;

  localparam int FB = 16;
  localparam longint ONE = 64'sd1 << FB;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic command;
  logic [IDX_W-1:0] table_index;
  logic [7:0] table_value;
  logic signed [COORD_W-1:0] coord_x, coord_y, coord_z;
  logic out_valid;
  logic out_stall;
  logic [NOISE_W-1:0] noise_value;

  gradient_noise_3d dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .command(command), .table_index(table_index), .table_value(table_value),
    .coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z),
    .out_valid(out_valid), .out_stall(out_stall), .noise_value(noise_value)
  );

  // One stimulus row; has_known marks a result typed in by hand.
  typedef struct {
    logic cmd;
    logic [7:0] idx;
    logic [7:0] val;
    logic [31:0] x, y, z;
    bit has_known;
    logic [15:0] known;
  } stim_row_t;

  logic [7:0] perm_copy [TABLE_SIZE];
  logic [15:0] noise_queue [$];
  int errors = 0;
  int mismatches = 0;
  bit quiet_phase = 0;
  bit hold_long = 0;

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("Regression FAIL");
    $finish;
  end

  // Arithmetic shift right by the fraction width, floor toward minus infinity.
  function automatic longint floor_fx(input longint v);
    floor_fx = v >>> FB;
  endfunction

  function automatic longint fade(input longint f);
    longint t2, t3, q, r;
    t2 = (f * f) >> FB;
    t3 = (t2 * f) >> FB;
    q = 6 * t2 - 15 * f + 10 * ONE;
    if (q < 0) q = 0;
    r = (t3 * q) >> FB;
    if (r > ONE) r = ONE;
    fade = r;
  endfunction

  function automatic longint mix(input longint t, input longint a, input longint b);
    mix = a + floor_fx(t * (b - a));
  endfunction

  function automatic longint grad(input logic [7:0] hash, input longint x,
                                  input longint y, input longint z);
    logic [3:0] h;
    longint u, v;
    h = hash[3:0];
    u = (h < 8) ? x : y;
    v = (h < 4) ? y : ((h == 12 || h == 14) ? x : z);
    grad = (h[0] ? -u : u) + (h[1] ? -v : v);
  endfunction

  function automatic logic [7:0] pt(input logic [7:0] i);
    pt = perm_copy[i];
  endfunction

  function automatic logic [15:0] predict_noise(input logic [31:0] cx,
                                                input logic [31:0] cy,
                                                input logic [31:0] cz);
    logic [7:0] xi, yi, zi, a, aa, ab, b, ba, bb;
    longint fx, fy, fz, u, v, w, x1, y1, z1, res, sv;
    xi = cx[23:16]; yi = cy[23:16]; zi = cz[23:16];
    fx = cx[15:0]; fy = cy[15:0]; fz = cz[15:0];
    u = fade(fx); v = fade(fy); w = fade(fz);
    a = pt(xi) + yi; aa = pt(a) + zi; ab = pt(a + 8'd1) + zi;
    b = pt(xi + 8'd1) + yi; ba = pt(b) + zi; bb = pt(b + 8'd1) + zi;
    x1 = fx - ONE; y1 = fy - ONE; z1 = fz - ONE;
    res = mix(w,
              mix(v, mix(u, grad(pt(aa), fx, fy, fz), grad(pt(ba), x1, fy, fz)),
                     mix(u, grad(pt(ab), fx, y1, fz), grad(pt(bb), x1, y1, fz))),
              mix(v, mix(u, grad(pt(aa + 8'd1), fx, fy, z1),
                            grad(pt(ba + 8'd1), x1, fy, z1)),
                     mix(u, grad(pt(ab + 8'd1), fx, y1, z1),
                            grad(pt(bb + 8'd1), x1, y1, z1))));
    sv = res + ONE;
    if (sv < 0) sv = 0;
    sv = (sv << 15) >> FB;
    if (sv > 65535) sv = 65535;
    predict_noise = sv[15:0];
  endfunction

  // Offer one item, wait until accepted, and update the predictor.
  task automatic send_item(input stim_row_t r);
    int gap;
    if (!quiet_phase && $urandom_range(0, 3) == 0) begin
      in_valid <= 0;
      gap = $urandom_range(1, 5);
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1;
    command <= r.cmd;
    table_index <= r.idx;
    table_value <= r.val;
    coord_x <= r.x; coord_y <= r.y; coord_z <= r.z;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (r.cmd == CMD_LOAD) begin
      perm_copy[r.idx] = r.val;
    end else if (r.has_known) begin
      noise_queue.push_back(r.known);
    end else begin
      noise_queue.push_back(predict_noise(r.x, r.y, r.z));
    end
    @(negedge clk);
  endtask

  function automatic stim_row_t eval_row(input logic [31:0] x, input logic [31:0] y,
                                         input logic [31:0] z);
    stim_row_t r;
    r.cmd = CMD_EVAL; r.idx = 8'($urandom); r.val = 8'($urandom);
    r.x = x; r.y = y; r.z = z; r.has_known = 0; r.known = 0;
    eval_row = r;
  endfunction

  // Output side: random stall bursts, one long hold, result checking.
  initial begin
    int n;
    out_stall = 0;
    forever begin
      @(negedge clk);
      if (hold_long) begin
        out_stall <= 1;
        repeat (60) @(negedge clk);
        out_stall <= 0;
        hold_long = 0;
      end else if (!quiet_phase && $urandom_range(0, 4) == 0) begin
        out_stall <= 1;
        n = $urandom_range(1, 5);
        repeat (n) @(negedge clk);
        out_stall <= 0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (noise_queue.size() == 0) begin
        errors++;
        if (mismatches++ < 10) $display("unexpected result %0d", noise_value);
      end else if (noise_queue[0] !== noise_value) begin
        errors++;
        if (mismatches++ < 10)
          $display("noise mismatch: expected %0d actual %0d", noise_queue[0],
                   noise_value);
        void'(noise_queue.pop_front());
      end else begin
        void'(noise_queue.pop_front());
      end
    end
  end

  initial begin
    stim_row_t directed [$];
    stim_row_t r;
    int k, wait_cycles;
    rst = 1; in_valid = 0; command = CMD_LOAD; table_index = 0; table_value = 0;
    coord_x = 0; coord_y = 0; coord_z = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Fill the table with a random permutation so no unwritten entry is read.
    for (int i = 0; i < TABLE_SIZE; i++) perm_copy[i] = 8'(i);
    for (int i = TABLE_SIZE - 1; i > 0; i--) begin
      logic [7:0] tmp;
      k = $urandom_range(0, i);
      tmp = perm_copy[i]; perm_copy[i] = perm_copy[k]; perm_copy[k] = tmp;
    end
    for (int i = 0; i < TABLE_SIZE; i++) begin
      r = eval_row(32'hFFFF_FFFF, 0, 0);
      r.cmd = CMD_LOAD; r.idx = 8'(i); r.val = perm_copy[i];
      send_item(r);
    end

    // Directed rows: lattice points give zero noise, i.e. exactly half scale.
    r = eval_row(0, 0, 0); r.has_known = 1; r.known = 16'd32768; directed.push_back(r);
    r = eval_row(32'h7FFF_0000, 32'h8000_0000, 32'h0001_0000);
    r.has_known = 1; r.known = 16'd32768; directed.push_back(r);
    directed.push_back(eval_row(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    directed.push_back(eval_row(32'h8000_0000, 32'h8000_0001, 32'hFFFF_FFFF));
    directed.push_back(eval_row(32'h0000_FFFF, 32'h0000_8000, 32'h0000_0001));
    directed.push_back(eval_row(32'hFFFF_8000, 32'h00FF_4000, 32'hFF00_C000));
    directed.push_back(eval_row(32'h0000_8000, 32'h0000_8000, 32'h0000_8000));
    directed.push_back(eval_row(32'hFFFF_0001, 32'h0001_FFFF, 32'h55AA_AA55));
    // Reload a few entries with extreme values, then evaluate through them.
    r = eval_row(0, 0, 0); r.cmd = CMD_LOAD; r.idx = 8'd255; r.val = 8'd0;
    directed.push_back(r);
    r.idx = 8'd0; r.val = 8'd255; directed.push_back(r);
    directed.push_back(eval_row(32'h00FF_7FFF, 32'h00FF_1234, 32'h00FF_FEDC));
    directed.push_back(eval_row(32'h0000_3333, 32'h00FE_CCCC, 32'h0001_9999));
    foreach (directed[i]) send_item(directed[i]);

    // Random part; a long output hold partway fills the pipeline.
    for (int i = 0; i < 940; i++) begin
      if (i == 300) hold_long = 1;
      if (i == 600) begin
        in_valid <= 0;
        wait_cycles = 0;
        while (noise_queue.size() != 0 && wait_cycles < 10000) begin
          @(negedge clk); wait_cycles++;
        end
      end
      if (i == 800) quiet_phase = 1;
      if ($urandom_range(0, 9) == 0) begin
        r = eval_row($urandom, $urandom, $urandom);
        r.cmd = CMD_LOAD;
      end else if ($urandom_range(0, 3) == 0) begin
        r = eval_row({$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom)},
                     {16'($urandom_range(0, 3)), 16'($urandom)},
                     {16'($urandom), $urandom_range(0, 1) ? 16'hFFFF : 16'h0000});
      end else begin
        r = eval_row($urandom, $urandom, $urandom);
      end
      send_item(r);
    end
    in_valid <= 0;

    wait_cycles = 0;
    while (noise_queue.size() != 0 && wait_cycles < 20000) begin
      @(negedge clk); wait_cycles++;
    end
    repeat (20) @(negedge clk);
    if (errors == 0 && noise_queue.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire

/* gradient_noise_3d.f */
hdl/gnz_pkg.sv
hdl/gnz_perm_ram.sv
hdl/gnz_fade.sv
hdl/gnz_lerp.sv
hdl/gradient_noise_3d.sv
test/gradient_noise_3d_tb.sv
